// ===== hdl/ssg_pkg.sv =====
`timescale 1ns / 1ps
package ssg_pkg;

	localparam int ROM_ROWS = 39;
	localparam int MAX_DEG  = 8;
	localparam int VAL_W    = 30;
	localparam int DIMIDX_W = 6;
	localparam int BC_W     = 5;
	localparam int ROW_W    = 6;

	typedef enum logic [1:0] {
		CMD_INIT = 2'd0,
		CMD_GEN  = 2'd1,
		CMD_SKIP = 2'd2
	} cmd_t;

	localparam logic REG_DIMENSIONS = 1'b0;
	localparam logic REG_MAX_POINTS = 1'b1;

	// primitive polynomials, one per dimension above the first
	localparam logic [8:0] POLY [ROM_ROWS] = '{
		9'd3,   9'd7,   9'd11,  9'd13,  9'd19,  9'd25,  9'd37,  9'd59,
		9'd47,  9'd61,  9'd55,  9'd41,  9'd67,  9'd97,  9'd91,  9'd109,
		9'd103, 9'd115, 9'd131, 9'd193, 9'd137, 9'd145, 9'd143, 9'd241,
		9'd157, 9'd185, 9'd167, 9'd229, 9'd171, 9'd213, 9'd191, 9'd253,
		9'd203, 9'd211, 9'd239, 9'd247, 9'd285, 9'd369, 9'd299
	};

	localparam logic [3:0] POLY_DEG [ROM_ROWS] = '{
		4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5,
		4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
		4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
		4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8
	};

	// initial odd numbers m[0..deg-1]
	localparam logic [6:0] POLY_INIT [ROM_ROWS][MAX_DEG] = '{
		'{7'd1, 7'd1, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd7,  7'd0,  7'd0,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd5,  7'd0,  7'd0,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd1,  7'd1,  7'd0,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd3,  7'd7,  7'd0,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd3,  7'd9,  7'd9,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd7,  7'd13, 7'd3,  7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd5,  7'd11, 7'd27, 7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd5,  7'd1,  7'd15, 7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd7,  7'd3,  7'd29, 7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd7,  7'd7,  7'd21, 7'd0,  7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd1,  7'd9,  7'd23, 7'd37, 7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd3,  7'd5,  7'd19, 7'd33, 7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd3,  7'd13, 7'd11, 7'd7,  7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd7,  7'd13, 7'd25, 7'd5,  7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd5,  7'd11, 7'd7,  7'd11, 7'd0,   7'd0},
		'{7'd1, 7'd1, 7'd1,  7'd3,  7'd13, 7'd39, 7'd0,   7'd0},
		'{7'd1, 7'd3, 7'd1,  7'd15, 7'd17, 7'd63, 7'd13,  7'd0},
		'{7'd1, 7'd1, 7'd5,  7'd5,  7'd1,  7'd27, 7'd33,  7'd0},
		'{7'd1, 7'd3, 7'd3,  7'd3,  7'd25, 7'd17, 7'd115, 7'd0},
		'{7'd1, 7'd1, 7'd3,  7'd15, 7'd29, 7'd15, 7'd41,  7'd0},
		'{7'd1, 7'd3, 7'd1,  7'd7,  7'd3,  7'd23, 7'd79,  7'd0},
		'{7'd1, 7'd3, 7'd7,  7'd9,  7'd31, 7'd29, 7'd17,  7'd0},
		'{7'd1, 7'd1, 7'd5,  7'd13, 7'd11, 7'd3,  7'd29,  7'd0},
		'{7'd1, 7'd3, 7'd1,  7'd9,  7'd5,  7'd21, 7'd119, 7'd0},
		'{7'd1, 7'd1, 7'd3,  7'd1,  7'd23, 7'd13, 7'd75,  7'd0},
		'{7'd1, 7'd3, 7'd3,  7'd11, 7'd27, 7'd31, 7'd73,  7'd0},
		'{7'd1, 7'd1, 7'd7,  7'd7,  7'd19, 7'd25, 7'd105, 7'd0},
		'{7'd1, 7'd3, 7'd5,  7'd5,  7'd21, 7'd9,  7'd7,   7'd0},
		'{7'd1, 7'd1, 7'd1,  7'd15, 7'd5,  7'd49, 7'd59,  7'd0},
		'{7'd1, 7'd1, 7'd1,  7'd1,  7'd1,  7'd33, 7'd65,  7'd0},
		'{7'd1, 7'd3, 7'd5,  7'd15, 7'd17, 7'd19, 7'd21,  7'd0},
		'{7'd1, 7'd1, 7'd7,  7'd11, 7'd13, 7'd29, 7'd3,   7'd0},
		'{7'd1, 7'd3, 7'd7,  7'd5,  7'd7,  7'd11, 7'd113, 7'd0},
		'{7'd1, 7'd1, 7'd5,  7'd3,  7'd15, 7'd19, 7'd61,  7'd0},
		'{7'd1, 7'd3, 7'd1,  7'd1,  7'd9,  7'd27, 7'd89,  7'd7},
		'{7'd1, 7'd1, 7'd3,  7'd7,  7'd31, 7'd15, 7'd45,  7'd23},
		'{7'd1, 7'd3, 7'd3,  7'd9,  7'd9,  7'd25, 7'd107, 7'd39}
	};

endpackage

// ===== hdl/ssg_ram.sv =====
`timescale 1ns / 1ps
module ssg_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1200,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/ssg_cell.sv =====
`timescale 1ns / 1ps
module ssg_cell #(
	parameter int WIDTH = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             shift,
	input  logic [WIDTH-1:0] nbr,
	input  logic [WIDTH-1:0] mix,
	output logic [WIDTH-1:0] val
);

	logic [WIDTH-1:0] val_q;

	// takes the neighbor's value, folded with mix, on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (clr) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= nbr ^ mix;
		end
	end

	assign val = val_q;

endmodule

// ===== hdl/ssg_dirgen.sv =====
`timescale 1ns / 1ps
module ssg_dirgen import ssg_pkg::*; #(
	parameter int MAX_DIMS = 40,
	parameter int DIR_BITS = 30,
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
	localparam int KW = (DIR_BITS > 1) ? $clog2(DIR_BITS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                step,
	output logic [DIR_BITS-1:0] dir_word,
	output logic                done
);

	logic [DW-1:0]       d_q;
	logic [KW-1:0]       k_q;
	logic [DIR_BITS-1:0] win_q [MAX_DEG];   // win_q[j] holds m[k-1-j]
	logic [ROW_W-1:0]    row;
	logic [3:0]          deg;
	logic [8:0]          pol;
	logic [7:0]          k8;
	logic [DIR_BITS-1:0] m_cur;
	logic [KW-1:0]       shamt;

	always_comb begin
		row   = (d_q == '0) ? '0 : ROW_W'(d_q) - ROW_W'(1);
		deg   = POLY_DEG[row];
		pol   = POLY[row];
		k8    = 8'(k_q);
		m_cur = '0;
		if (d_q == '0) begin
			m_cur = DIR_BITS'(1);
		end else if (k8 < 8'(deg)) begin
			m_cur = DIR_BITS'(POLY_INIT[row][k8[2:0]]);
		end else begin
			// m[k] = m[k-deg] ^ sum of a_b * m[k-deg+b] << (deg-b)
			for (int j = 0; j < MAX_DEG; j++) begin
				if (j == int'(deg) - 1) begin
					m_cur = m_cur ^ win_q[j];
				end
				if ((j < int'(deg)) && pol[int'(deg) - 1 - j]) begin
					m_cur = m_cur ^ (win_q[j] << (j + 1));
				end
			end
		end
		shamt    = KW'(DIR_BITS - 1) - k_q;
		dir_word = m_cur << shamt;
		done     = (d_q == DW'(MAX_DIMS - 1)) && (k_q == KW'(DIR_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
			k_q <= '0;
		end else if (start) begin
			d_q <= '0;
			k_q <= '0;
		end else if (step) begin
			if (k_q == KW'(DIR_BITS - 1)) begin
				k_q <= '0;
				d_q <= d_q + DW'(1);
			end else begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			win_q[0] <= m_cur;
			for (int j = 1; j < MAX_DEG; j++) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

endmodule

// ===== hdl/sobol_sequence_generator.sv =====
`timescale 1ns / 1ps
// init: writes the whole direction table (one direction word written per cycle), then the reply
// generate: steps through all MAX_DIMS dimensions in turn (ram read, then xor in ring)
// skip: walks the whole table, one table read per cycle; zero skip or exhausted goes to the reply
// one command in flight at a time; the next word is taken once the last reply is loaded
// arst_n clears control, counts, previous vectors and config registers to their defaults
// the direction table has no reset and is written by init only
module sobol_sequence_generator import ssg_pkg::*; #(
	parameter int MAX_DIMS = 40,
	parameter int DIR_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // cmd[1:0], skip_count[31:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // dim_index[5:0], value[35:6], zero[39:36]
	output logic        m_tlast,
	output logic        m_tuser,    // exhausted[0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [29:0] cfg_wdata
);

	localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int KW    = (DIR_BITS > 1) ? $clog2(DIR_BITS) : 1;
	localparam int DEPTH = MAX_DIMS * DIR_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_GEN_RD,
		ST_GEN_XOR,
		ST_SKIP,
		ST_DONE
	} state_t;

	state_t state_q;

	// config registers
	logic [DIMIDX_W-1:0] dims_q;
	logic [VAL_W-1:0]    maxp_q;

	// sequence state
	logic [VAL_W-1:0]    pc_q;
	logic [BC_W-1:0]     bc_q;
	logic [DIR_BITS-1:0] gray_q;

	// sequencer registers
	logic [DW-1:0]       d_q;
	logic [AW-1:0]       addr_q;
	logic                exh_q;
	logic                iss_q;
	logic [KW-1:0]       kiss_q;
	logic                v_s1;
	logic [KW-1:0]       k_s1;
	logic [DIR_BITS-1:0] acc_q;

	// output word register
	logic                out_valid_q;
	logic [DIMIDX_W-1:0] out_dim_q;
	logic [VAL_W-1:0]    out_val_q;
	logic                out_last_q;
	logic                out_exh_q;

	logic [1:0]          in_cmd;
	logic [VAL_W-1:0]    in_skip;
	logic                in_acc;
	logic                out_free;
	logic                out_load;
	logic [VAL_W-1:0]    cap;
	logic [BC_W-1:0]     nb;
	logic [KW-1:0]       z;
	logic [DIMIDX_W-1:0] nd;
	logic [VAL_W-1:0]    target;
	logic [DIR_BITS-1:0] acc_new;

	// ring of previous vectors, head is the current dimension
	logic [DIR_BITS-1:0] ring [MAX_DIMS];
	logic                ring_clr;
	logic                ring_shift;
	logic [DIR_BITS-1:0] tail_nbr;
	logic [DIR_BITS-1:0] tail_mix;
	logic [DIR_BITS-1:0] head;

	// direction table
	logic                ram_we;
	logic [DIR_BITS-1:0] ram_rdata;
	logic [DIR_BITS-1:0] dg_word;
	logic                dg_done;
	logic                dg_start;
	logic                dg_step;

	assign in_cmd   = s_tdata[1:0];
	assign in_skip  = s_tdata[31:2];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign head     = ring[0];

	always_comb begin
		// capacity is 2^bit_count - 1
		cap = VAL_W'((31'(1) << bc_q) - 31'(1));

		// bit length of max_points, clamped to DIR_BITS
		nb = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (maxp_q[i]) begin
				nb = BC_W'(i + 1);
			end
		end
		if (nb > BC_W'(DIR_BITS)) begin
			nb = BC_W'(DIR_BITS);
		end

		// lowest zero bit of the point count
		z = KW'(DIR_BITS - 1);
		for (int i = DIR_BITS - 1; i >= 0; i--) begin
			if (!pc_q[i]) begin
				z = KW'(i);
			end
		end

		// active dimension count, zero reads as one, saturates at the top
		if (dims_q == '0) begin
			nd = DIMIDX_W'(1);
		end else if (dims_q > DIMIDX_W'(MAX_DIMS)) begin
			nd = DIMIDX_W'(MAX_DIMS);
		end else begin
			nd = dims_q;
		end

		// output register takes a new word this cycle
		out_load = ((state_q == ST_GEN_XOR) && (DIMIDX_W'(d_q) < nd)) ||
			((state_q == ST_DONE) && out_free);

		target  = pc_q + in_skip;
		acc_new = ((k_s1 == '0) ? '0 : acc_q) ^ (gray_q[k_s1] ? ram_rdata : '0);

		ring_clr   = in_acc && (in_cmd == CMD_INIT);
		ring_shift = 1'b0;
		tail_nbr   = head;
		tail_mix   = ram_rdata;
		if (state_q == ST_GEN_XOR) begin
			ring_shift = 1'b1;
		end else if (state_q == ST_SKIP) begin
			ring_shift = v_s1 && (k_s1 == KW'(DIR_BITS - 1));
			tail_nbr   = '0;
			tail_mix   = acc_new;
		end

		ram_we   = (state_q == ST_INIT);
		dg_step  = (state_q == ST_INIT);
		dg_start = ring_clr;
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_DIMS; gi++) begin : g_cell
			if (gi == MAX_DIMS - 1) begin : g_tail
				ssg_cell #(.WIDTH(DIR_BITS)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.clr    (ring_clr),
					.shift  (ring_shift),
					.nbr    (tail_nbr),
					.mix    (tail_mix),
					.val    (ring[gi])
				);
			end else begin : g_body
				ssg_cell #(.WIDTH(DIR_BITS)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.clr    (ring_clr),
					.shift  (ring_shift),
					.nbr    (ring[gi+1]),
					.mix    ('0),
					.val    (ring[gi])
				);
			end
		end
	endgenerate

	ssg_dirgen #(.MAX_DIMS(MAX_DIMS), .DIR_BITS(DIR_BITS)) u_dirgen (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dg_start),
		.step     (dg_step),
		.dir_word (dg_word),
		.done     (dg_done)
	);

	ssg_ram #(.WIDTH(DIR_BITS), .DEPTH(DEPTH)) u_dir_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (dg_word),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMIDX_W'(1);
			maxp_q <= VAL_W'(65535);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMENSIONS: dims_q <= cfg_wdata[DIMIDX_W-1:0];
				REG_MAX_POINTS: maxp_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// command sequencer and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			bc_q        <= '0;
			gray_q      <= '0;
			d_q         <= '0;
			addr_q      <= '0;
			exh_q       <= 1'b0;
			iss_q       <= 1'b0;
			kiss_q      <= '0;
			v_s1        <= 1'b0;
			k_s1        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_dim_q   <= '0;
			out_val_q   <= '0;
			out_last_q  <= 1'b0;
			out_exh_q   <= 1'b0;
		end else begin
			if (m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_cmd)
							CMD_INIT: begin
								bc_q    <= nb;
								pc_q    <= '0;
								addr_q  <= '0;
								state_q <= ST_INIT;
							end
							CMD_GEN: begin
								if (pc_q >= cap) begin
									exh_q   <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									pc_q    <= pc_q + VAL_W'(1);
									addr_q  <= AW'(z);
									d_q     <= '0;
									state_q <= ST_GEN_RD;
								end
							end
							CMD_SKIP: begin
								if (in_skip == '0) begin
									exh_q   <= 1'b0;
									state_q <= ST_DONE;
								end else if (in_skip > cap - pc_q) begin
									exh_q   <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									pc_q    <= target;
									gray_q  <= DIR_BITS'(target ^ (target >> 1));
									addr_q  <= '0;
									d_q     <= '0;
									iss_q   <= 1'b1;
									kiss_q  <= '0;
									v_s1    <= 1'b0;
									state_q <= ST_SKIP;
								end
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					addr_q <= addr_q + AW'(1);
					if (dg_done) begin
						exh_q   <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_GEN_RD: begin
					// wait for room so the xor step can always load its word
					if (out_free) begin
						state_q <= ST_GEN_XOR;
					end
				end
				ST_GEN_XOR: begin
					if (DIMIDX_W'(d_q) < nd) begin
						out_valid_q <= 1'b1;
						out_dim_q   <= DIMIDX_W'(d_q);
						out_val_q   <= VAL_W'(head ^ ram_rdata) << (VAL_W - DIR_BITS);
						out_last_q  <= (DIMIDX_W'(d_q) == nd - DIMIDX_W'(1));
						out_exh_q   <= 1'b0;
					end
					d_q    <= d_q + DW'(1);
					addr_q <= addr_q + AW'(DIR_BITS);
					if (d_q == DW'(MAX_DIMS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_GEN_RD;
					end
				end
				ST_SKIP: begin
					// read side: one table word per cycle
					v_s1 <= iss_q;
					k_s1 <= kiss_q;
					if (iss_q) begin
						addr_q <= addr_q + AW'(1);
						kiss_q <= (kiss_q == KW'(DIR_BITS - 1)) ? '0 : kiss_q + KW'(1);
						if (addr_q == AW'(DEPTH - 1)) begin
							iss_q <= 1'b0;
						end
					end
					// accumulate side: gray-coded sum per dimension
					if (v_s1) begin
						acc_q <= acc_new;
						if (k_s1 == KW'(DIR_BITS - 1)) begin
							d_q <= d_q + DW'(1);
							if (d_q == DW'(MAX_DIMS - 1)) begin
								exh_q   <= 1'b0;
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_dim_q   <= '0;
						out_val_q   <= '0;
						out_last_q  <= 1'b1;
						out_exh_q   <= exh_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_val_q, out_dim_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_exh_q;

	// the point count never passes capacity between commands
	a_pc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pc_q <= cap))
		else $error("point count beyond capacity");

	// init restarts the count
	a_init_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_cmd == CMD_INIT)) |=> (pc_q == '0))
		else $error("init did not clear point count");

	// a granted generate advances the count by one
	a_gen_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_cmd == CMD_GEN) && (pc_q < cap)) |=> (pc_q == $past(pc_q) + VAL_W'(1)))
		else $error("generate did not advance point count");

	// coordinate words stay inside the active dimensions
	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_exh_q) |-> (out_dim_q < nd))
		else $error("dimension index out of range");

	// table writes happen only during init
	a_ram_we: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!s_tready && (pc_q == '0)))
		else $error("table write outside init");

endmodule

// ===== tb/sv/sobol_sequence_checker.sv =====
`timescale 1ns / 1ps
module sobol_sequence_checker import ssg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [29:0] cfg_wdata,
	output int          pending,
	output int          fails
);

	localparam int NDIM = 40;
	localparam int NBIT = 30;

	typedef struct packed {
		logic [5:0]  dim;
		logic [29:0] coord;
		logic        last;
		logic        exh;
	} coord_word_t;

	logic [29:0] dir_words [NDIM][NBIT];
	logic [29:0] prev_coord [NDIM];
	logic [29:0] point_cnt;
	logic [4:0]  nbits;
	logic [5:0]  dims_reg;
	logic [29:0] max_pts_reg;
	coord_word_t coord_q [$];

	initial fails = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		fails++;
	endtask

	function automatic int live_dims();
		if (dims_reg == 0) return 1;
		if (dims_reg > NDIM) return NDIM;
		return dims_reg;
	endfunction

	function automatic logic [29:0] plan_cap();
		return 30'((32'd1 << nbits) - 32'd1);
	endfunction

	task automatic push_word(input int d, input logic [29:0] v, input logic l, input logic e);
		coord_word_t w;
		w.dim = 6'(d);
		w.coord = v;
		w.last = l;
		w.exh = e;
		coord_q.push_back(w);
	endtask

	// direction numbers from the polynomial rom, kept as q0.30 fractions
	task automatic build_dirs();
		logic [31:0] m [NBIT];
		logic [31:0] nv;
		int row, deg;
		logic [8:0] p;
		for (int d = 0; d < NDIM; d++) begin
			if (d == 0) begin
				for (int k = 0; k < NBIT; k++) m[k] = 1;
			end else begin
				row = (d - 1) % ROM_ROWS;
				p = POLY[row];
				deg = POLY_DEG[row];
				for (int k = 0; k < deg; k++) m[k] = POLY_INIT[row][k];
				for (int k = deg; k < NBIT; k++) begin
					nv = m[k - deg];
					for (int b = 0; b < deg; b++)
						if (p[b]) nv ^= m[k - deg + b] << (deg - b);
					m[k] = nv;
				end
			end
			for (int k = 0; k < NBIT; k++) dir_words[d][k] = 30'(m[k] << (NBIT - 1 - k));
		end
	endtask

	task automatic predict(input logic [1:0] op, input logic [29:0] skip);
		logic [31:0] t, target, gray, z;
		logic [29:0] acc;
		int nd;
		nd = live_dims();
		case (op)
			CMD_INIT: begin
				nbits = 0;
				for (t = max_pts_reg; t != 0; t >>= 1) nbits++;
				build_dirs();
				for (int d = 0; d < NDIM; d++) prev_coord[d] = '0;
				point_cnt = '0;
				push_word(0, '0, 1'b1, 1'b0);
			end
			CMD_GEN: begin
				if (point_cnt >= plan_cap()) begin
					push_word(0, '0, 1'b1, 1'b1);
				end else begin
					z = 0;
					t = point_cnt;
					while (t[0]) begin
						z++;
						t >>= 1;
					end
					if (z >= NBIT) z = NBIT - 1;
					point_cnt = point_cnt + 1;
					for (int d = 0; d < NDIM; d++) prev_coord[d] ^= dir_words[d][z];
					for (int d = 0; d < nd; d++)
						push_word(d, prev_coord[d], d + 1 == nd, 1'b0);
				end
			end
			CMD_SKIP: begin
				if (skip > plan_cap() - point_cnt) begin
					push_word(0, '0, 1'b1, 1'b1);
				end else begin
					target = point_cnt + skip;
					gray = target ^ (target >> 1);
					for (int d = 0; d < NDIM; d++) begin
						acc = '0;
						for (int k = 0; k < NBIT; k++)
							if (gray[k]) acc ^= dir_words[d][k];
						prev_coord[d] = acc;
					end
					point_cnt = 30'(target);
					push_word(0, '0, 1'b1, 1'b0);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		coord_word_t w;
		if (!arst_n) begin
			for (int d = 0; d < NDIM; d++) prev_coord[d] = '0;
			point_cnt = '0;
			nbits = '0;
			dims_reg = 6'd1;
			max_pts_reg = 30'd65535;
			coord_q.delete();
		end else begin
			// results first: an accepted command can't answer at its own edge
			if (m_tvalid && m_tready) begin
				if (coord_q.size() == 0) begin
					report($sformatf("unexpected word dim=%0d value=%h", m_tdata[5:0],
						m_tdata[35:6]));
				end else begin
					w = coord_q.pop_front();
					if (m_tdata[5:0] != w.dim)
						report($sformatf("dim_index %0d, want %0d", m_tdata[5:0], w.dim));
					if (m_tdata[35:6] != w.coord)
						report($sformatf("value %h, want %h (dim %0d)", m_tdata[35:6],
							w.coord, w.dim));
					if (m_tdata[39:36] != 0)
						report("padding bits not zero");
					if (m_tlast != w.last)
						report($sformatf("last %b, want %b", m_tlast, w.last));
					if (m_tuser != w.exh)
						report($sformatf("exhausted %b, want %b", m_tuser, w.exh));
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_DIMENSIONS) dims_reg = cfg_wdata[5:0];
				else max_pts_reg = cfg_wdata;
			end
			if (s_tvalid && s_tready) predict(s_tdata[1:0], s_tdata[31:2]);
		end
		pending = coord_q.size();
	end

endmodule

// ===== tb/sv/tb_sobol_sequence_generator.sv =====
`timescale 1ns / 1ps
module tb_sobol_sequence_generator;
	import ssg_pkg::*;

	// spare command code, the block must drop it silently
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// init and skip walk the whole table, so idle time before a write covers them
	localparam int SETTLE = 1300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;     // cmd[1:0], skip_count[31:2]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // dim_index[5:0], value[35:6], zero[39:36]
	logic        m_tlast;
	logic        m_tuser;          // exhausted[0]
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [29:0] cfg_wdata = '0;

	int pending;
	int fails;
	bit calm = 1'b0;       // no idling on either side while set
	bit hold_go = 1'b0;    // asks the receiver for one long hold-off
	int hold_left = 0;

	always #5 clk = ~clk;

	sobol_sequence_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	sobol_sequence_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.pending(pending), .fails(fails)
	);

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 17);
			end
		end
	end

	task automatic send_cmd(input logic [1:0] op, input logic [29:0] skip);
		s_tdata <= {skip, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		// random gap after the word, valid stays up otherwise
		if (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// drain every reply and let the block settle before touching a register
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [29:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [29:0] pick_skip();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 30'($urandom_range(0, 20));
		if (r < 80) return 30'($urandom_range(0, 65535));
		return 30'($urandom);
	endfunction

	initial begin
		int r;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// before any init: zero capacity, so only skip of zero completes
		send_cmd(CMD_GEN, '0);
		send_cmd(CMD_SKIP, '0);
		send_cmd(CMD_SKIP, 30'd5);
		send_cmd(CMD_UNUSED, 30'h2AAAAAAA);
		// zero dimensions act as one, zero max_points gives no capacity
		write_reg(REG_DIMENSIONS, 30'd0);
		write_reg(REG_MAX_POINTS, 30'd0);
		send_cmd(CMD_INIT, '0);
		send_cmd(CMD_GEN, '0);
		send_cmd(CMD_SKIP, '0);
		// tiny capacity, full width vectors, run into the limit
		write_reg(REG_DIMENSIONS, 30'd40);
		write_reg(REG_MAX_POINTS, 30'd3);
		send_cmd(CMD_INIT, '0);
		repeat (4) send_cmd(CMD_GEN, '0);
		send_cmd(CMD_INIT, '0);
		send_cmd(CMD_SKIP, 30'd3);
		send_cmd(CMD_SKIP, 30'd1);
		send_cmd(CMD_GEN, '0);
		// dimensions above the limit saturate, largest plan
		write_reg(REG_DIMENSIONS, 30'd63);
		write_reg(REG_MAX_POINTS, 30'h3FFFFFFF);
		send_cmd(CMD_INIT, '0);
		repeat (4) send_cmd(CMD_GEN, '0);
		send_cmd(CMD_SKIP, 30'h3FFFFFFF - 30'd4);
		send_cmd(CMD_SKIP, 30'h3FFFFFFF);
		send_cmd(CMD_GEN, '0);

		for (int n = 0; n < 280; n++) begin
			if (n % 40 == 0) begin
				r = $urandom_range(9);
				write_reg(REG_DIMENSIONS, r == 0 ? 30'($urandom_range(0, 63))
					: 30'($urandom_range(1, 40)));
				r = $urandom_range(9);
				write_reg(REG_MAX_POINTS, r < 2 ? 30'($urandom_range(1, 40))
					: r < 8 ? 30'($urandom_range(1, 1 << 20)) : 30'($urandom));
				send_cmd(CMD_INIT, '0);
			end
			if (n == 100) hold_go = 1'b1;
			if (n == 150) calm = 1'b1;
			if (n == 200) calm = 1'b0;
			if (n == 230) wait_idle();
			r = $urandom_range(99);
			if (r < 70) send_cmd(CMD_GEN, 30'($urandom));
			else if (r < 87) send_cmd(CMD_SKIP, pick_skip());
			else if (r < 93) send_cmd(CMD_INIT, 30'($urandom));
			else send_cmd(CMD_UNUSED, 30'($urandom));
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(negedge clk);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ssg_pkg.sv
hdl/ssg_ram.sv
hdl/ssg_cell.sv
hdl/ssg_dirgen.sv
hdl/sobol_sequence_generator.sv
tb/sv/sobol_sequence_checker.sv
tb/sv/tb_sobol_sequence_generator.sv
